/* rtl/mwlj_pkg.sv */
// Shared widths, constants and pipeline record types for the mirror wall force block.
`default_nettype none

package mwlj_pkg;

  // Field widths fixed by the item formats
  localparam int COORD_W = 32;
  localparam int REG_W   = 32;
  localparam int TYPE_W  = 2;
  localparam int IDX_W   = 3;
  localparam int FORCE_W = 48;

  // Internal datapath widths
  localparam int M_W    = 29;  // mirror distance, below 2^29 when in range
  localparam int DSQ_W  = 58;  // squared distance
  localparam int THR_W  = 57;  // range threshold
  localparam int LJ2_W  = 40;  // sigma^2/d^2 quotient; larger always saturates
  localparam int LJ6_W  = 48;  // sixth power; larger always saturates
  localparam int BIG_W  = 64;
  localparam int Q2_W   = 48;  // force magnitude quotient

  // 2^(1/3) with 24 fraction bits
  localparam logic [24:0] CBRT2_Q24 = 25'd21137968;

  // Full-scale force values
  localparam logic [FORCE_W-1:0] FORCE_POS = 48'h7FFF_FFFF_FFFF;
  localparam logic [FORCE_W-1:0] FORCE_NEG = 48'h8000_0000_0000;

  // Register bank select (top bit of the register index)
  localparam logic BANK_SIGMA = 1'b0;
  localparam logic BANK_EPS   = 1'b1;

  // Per-item flags and operands carried along the pipeline
  typedef struct packed {
    logic             applied;
    logic             zero;
    logic             eps0;
    logic             neg_d;
    logic [M_W-1:0]   m;
    logic [REG_W-1:0] e;
  } side_t;

  // Stage record of the sigma^2/d^2 divider
  typedef struct packed {
    side_t            side;
    logic             ovf;
    logic [DSQ_W-1:0] dsq;
    logic [DSQ_W-1:0] rem;
    logic [LJ2_W-1:0] q;
  } div1_t;

  // Stage record of the force magnitude divider
  typedef struct packed {
    side_t           side;
    logic            neg;
    logic            sat;
    logic [M_W-1:0]  rem;
    logic [Q2_W-1:0] low;
    logic [Q2_W-1:0] q;
  } div2_t;

endpackage

`default_nettype wire

/* rtl/mwlj_in_if.sv */
// Particle input channel: valid/ready with coordinate, wall position and type.
`default_nettype none

interface mwlj_in_if import mwlj_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coordinate;
  logic signed [COORD_W-1:0] wall_position;
  logic [TYPE_W-1:0]         type_id;

  modport source (output valid, output coordinate, output wall_position, output type_id,
                  input ready);
  modport sink   (input valid, input coordinate, input wall_position, input type_id,
                  output ready);
endinterface

`default_nettype wire

/* rtl/mwlj_out_if.sv */
// Force result channel: valid/ready with force and status flags.
`default_nettype none

interface mwlj_out_if import mwlj_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [FORCE_W-1:0] force_res;
  logic                      applied;
  logic                      saturated;

  modport source (output valid, output force_res, output applied, output saturated,
                  input ready);
  modport sink   (input valid, input force_res, input applied, input saturated,
                  output ready);
endinterface

`default_nettype wire

/* rtl/mwlj_cfg_if.sv */
// Register write channel: valid/ready with register index and write data.
`default_nettype none

interface mwlj_cfg_if import mwlj_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [REG_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

/* rtl/mirror_wall_lj_force_core.sv */
// Mirror wall Lennard-Jones force pipeline, top level.
//
//  channel  dir  payload                               accepted when
//  in_ch    in   coordinate, wall_position, type_id    valid & ready
//  out_ch   out  force_res, applied, saturated         valid & ready
//  cfg      in   index, wdata                          valid & ready (ready tied high)
//
// One item enters per cycle while the output is not stalled; the depth is set by the
// two bit-per-stage restoring dividers (40 and 48 quotient bits).
// The whole pipeline advances together whenever the output register is empty or taken;
// a stall at the output freezes every stage and holds input ready low.
// Reset clears the stage valid bits and loads the default sigma^2 and 24*epsilon values.
`default_nettype none

module mirror_wall_lj_force_core import mwlj_pkg::*; #(
  parameter int NUM_TYPES = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  mwlj_in_if.sink      in_ch,
  mwlj_out_if.source   out_ch,
  mwlj_cfg_if.sink     cfg
);

  localparam int TW     = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int SH_THR = 24 - FRAC_BITS;
  localparam int SH_OV1 = FRAC_BITS - 8;
  localparam int SH_OV2 = Q2_W - FRAC_BITS;
  localparam int NST    = 3 + LJ2_W + 10 + Q2_W + 1;

  // ---------------------------------------------------------------- registers
  logic [REG_W-1:0] sigma_sq [NUM_TYPES];
  logic [REG_W-1:0] eps24    [NUM_TYPES];

  assign cfg.ready = 1'b1;

  // Write the selected register; ignore types beyond the table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TYPES; i++) begin
        sigma_sq[i] <= REG_W'(1) << FRAC_BITS;
        eps24[i]    <= REG_W'(24) << FRAC_BITS;
      end
    end else if (cfg.valid && (int'(cfg.index[1:0]) < NUM_TYPES)) begin
      unique case (cfg.index[2])
        BANK_SIGMA: sigma_sq[TW'(cfg.index[1:0])] <= cfg.wdata;
        BANK_EPS:   eps24[TW'(cfg.index[1:0])]    <= cfg.wdata;
        default:    ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  logic           adv;
  logic [NST-1:0] vld;

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Advance the valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_ch.valid};
    end
  end

  assign out_ch.valid = vld[NST-1];

  // ---------------------------------------------------------------- stage A
  logic signed [COORD_W:0] diff;
  logic [COORD_W:0]        adiff;
  logic [TW-1:0]           tsel;

  assign diff  = $signed({in_ch.coordinate[COORD_W-1], in_ch.coordinate})
               - $signed({in_ch.wall_position[COORD_W-1], in_ch.wall_position});
  assign adiff = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;
  assign tsel  = (int'(in_ch.type_id) >= NUM_TYPES) ? TW'(NUM_TYPES - 1)
                                                     : TW'(in_ch.type_id);

  logic             a_far, a_neg;
  logic [M_W-1:0]   a_m;
  logic [REG_W-1:0] a_sq, a_e;

  // Mirror distance is twice the wall distance; select the type's registers
  always_ff @(posedge clk) begin
    if (adv) begin
      a_far <= |adiff[COORD_W:M_W-1];
      a_neg <= diff[COORD_W];
      a_m   <= {adiff[M_W-2:0], 1'b0};
      a_sq  <= sigma_sq[tsel];
      a_e   <= eps24[tsel];
    end
  end

  // ---------------------------------------------------------------- stage B
  logic [DSQ_W-1:0] dsq_w;
  logic [THR_W-1:0] thr_full;

  assign dsq_w    = a_m * a_m;
  assign thr_full = a_sq * CBRT2_Q24;

  logic             b_far, b_neg;
  logic [M_W-1:0]   b_m;
  logic [REG_W-1:0] b_sq, b_e;
  logic [DSQ_W-1:0] b_dsq;
  logic [THR_W-1:0] b_thr;

  // Square the distance and scale sigma^2 into the range threshold
  always_ff @(posedge clk) begin
    if (adv) begin
      b_far <= a_far;
      b_neg <= a_neg;
      b_m   <= a_m;
      b_sq  <= a_sq;
      b_e   <= a_e;
      b_dsq <= dsq_w;
      b_thr <= thr_full >> SH_THR;
    end
  end

  // ---------------------------------------------------------------- stage C
  div1_t            d1 [LJ2_W+1];
  logic [DSQ_W-1:0] c_rem0;

  assign c_rem0 = DSQ_W'(b_sq) << SH_OV1;

  // Range test, special cases and divider seed
  always_ff @(posedge clk) begin
    if (adv) begin
      d1[0].side.applied <= !b_far && (b_dsq < DSQ_W'(b_thr));
      d1[0].side.zero    <= (b_m == '0);
      d1[0].side.eps0    <= (b_e == '0);
      d1[0].side.neg_d   <= b_neg;
      d1[0].side.m       <= b_m;
      d1[0].side.e       <= b_e;
      d1[0].ovf          <= (c_rem0 >= b_dsq);
      d1[0].dsq          <= b_dsq;
      d1[0].rem          <= c_rem0;
      d1[0].q            <= '0;
    end
  end

  // ---------------------------------------------------------------- lj2 divider
  for (genvar i = 0; i < LJ2_W; i++) begin : g_div1
    logic [DSQ_W:0]   nr;
    logic             ge;
    logic [DSQ_W-1:0] rem_next;

    assign nr       = {d1[i].rem, 1'b0};
    assign ge       = nr >= {1'b0, d1[i].dsq};
    assign rem_next = ge ? DSQ_W'(nr - {1'b0, d1[i].dsq}) : nr[DSQ_W-1:0];

    // Resolve one quotient bit
    always_ff @(posedge clk) begin
      if (adv) begin
        d1[i+1].side <= d1[i].side;
        d1[i+1].ovf  <= d1[i].ovf;
        d1[i+1].dsq  <= d1[i].dsq;
        d1[i+1].rem  <= rem_next;
        d1[i+1].q    <= {d1[i].q[LJ2_W-2:0], ge};
      end
    end
  end

  // ---------------------------------------------------------------- lj2^2
  side_t            m1_side;
  logic             m1_sat;
  logic [LJ2_W-1:0] m1_lj2;
  logic [63:0]      m1_ll;
  logic [39:0]      m1_lh;
  logic [15:0]      m1_hh;

  // Form partial products of lj2 * lj2
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_side <= d1[LJ2_W].side;
      m1_sat  <= d1[LJ2_W].ovf;
      m1_lj2  <= d1[LJ2_W].q;
      m1_ll   <= d1[LJ2_W].q[31:0] * d1[LJ2_W].q[31:0];
      m1_lh   <= d1[LJ2_W].q[31:0] * d1[LJ2_W].q[39:32];
      m1_hh   <= d1[LJ2_W].q[39:32] * d1[LJ2_W].q[39:32];
    end
  end

  logic [79:0] m2_sum;
  assign m2_sum = 80'(m1_ll) + (80'(m1_lh) << 33) + (80'(m1_hh) << 64);

  side_t            m2_side;
  logic             m2_sat;
  logic [LJ2_W-1:0] m2_lj2;
  logic [47:0]      m2_t;

  // Sum and drop 32 fraction bits
  always_ff @(posedge clk) begin
    if (adv) begin
      m2_side <= m1_side;
      m2_sat  <= m1_sat;
      m2_lj2  <= m1_lj2;
      m2_t    <= m2_sum[79:32];
    end
  end

  // ---------------------------------------------------------------- lj6
  side_t       m3_side;
  logic        m3_sat;
  logic [63:0] m3_p0;
  logic [39:0] m3_p1;
  logic [47:0] m3_p2;
  logic [23:0] m3_p3;

  // Form partial products of (lj2^2) * lj2
  always_ff @(posedge clk) begin
    if (adv) begin
      m3_side <= m2_side;
      m3_sat  <= m2_sat;
      m3_p0   <= m2_t[31:0] * m2_lj2[31:0];
      m3_p1   <= m2_t[31:0] * m2_lj2[39:32];
      m3_p2   <= m2_t[47:32] * m2_lj2[31:0];
      m3_p3   <= m2_t[47:32] * m2_lj2[39:32];
    end
  end

  logic [87:0] m4_sum;
  assign m4_sum = 88'(m3_p0) + (88'(m3_p1) << 32) + (88'(m3_p2) << 32) + (88'(m3_p3) << 64);

  side_t            m4_side;
  logic             m4_sat;
  logic [LJ6_W-1:0] m4_lj6;

  // Sum; a sixth power past 48 bits saturates everything after it
  always_ff @(posedge clk) begin
    if (adv) begin
      m4_side <= m3_side;
      m4_sat  <= m3_sat | (|m4_sum[87:80]);
      m4_lj6  <= m4_sum[79:32];
    end
  end

  // ---------------------------------------------------------------- lj12
  side_t            m5_side;
  logic             m5_sat;
  logic [LJ6_W-1:0] m5_lj6;
  logic [63:0]      m5_ll;
  logic [47:0]      m5_lh;
  logic [31:0]      m5_hh;

  // Form partial products of lj6 * lj6
  always_ff @(posedge clk) begin
    if (adv) begin
      m5_side <= m4_side;
      m5_sat  <= m4_sat;
      m5_lj6  <= m4_lj6;
      m5_ll   <= m4_lj6[31:0] * m4_lj6[31:0];
      m5_lh   <= m4_lj6[31:0] * m4_lj6[47:32];
      m5_hh   <= m4_lj6[47:32] * m4_lj6[47:32];
    end
  end

  logic [95:0] m6_sum;
  assign m6_sum = 96'(m5_ll) + (96'(m5_lh) << 33) + (96'(m5_hh) << 64);

  side_t            m6_side;
  logic             m6_sat;
  logic [LJ6_W-1:0] m6_lj6;
  logic [BIG_W-1:0] m6_two12;

  // Double lj12; a set top bit overflows the doubling
  always_ff @(posedge clk) begin
    if (adv) begin
      m6_side  <= m5_side;
      m6_sat   <= m5_sat | m6_sum[95];
      m6_lj6   <= m5_lj6;
      m6_two12 <= {m6_sum[94:32], 1'b0};
    end
  end

  // ---------------------------------------------------------------- bracket term
  logic             m7_bneg;
  logic [BIG_W-1:0] m7_lj6x;

  assign m7_lj6x = BIG_W'(m6_lj6);
  assign m7_bneg = m6_two12 < m7_lj6x;

  side_t            m7_side;
  logic             m7_sat, m7_neg;
  logic [BIG_W-1:0] m7_bmag;

  // Sign and magnitude of 2*lj12 - lj6; saturated paths keep the sign of the offset
  always_ff @(posedge clk) begin
    if (adv) begin
      m7_side <= m6_side;
      m7_sat  <= m6_sat;
      m7_neg  <= m6_side.neg_d ^ (m7_bneg & !m6_sat);
      m7_bmag <= m7_bneg ? (m7_lj6x - m6_two12) : (m6_two12 - m7_lj6x);
    end
  end

  // ---------------------------------------------------------------- epsilon product
  side_t       m8_side;
  logic        m8_sat, m8_neg;
  logic [63:0] m8_pl, m8_ph;

  // Form partial products of eps24 * |B|
  always_ff @(posedge clk) begin
    if (adv) begin
      m8_side <= m7_side;
      m8_sat  <= m7_sat;
      m8_neg  <= m7_neg;
      m8_pl   <= m7_side.e * m7_bmag[31:0];
      m8_ph   <= m7_side.e * m7_bmag[63:32];
    end
  end

  side_t            m9_side;
  logic             m9_sat, m9_neg;
  logic [BIG_W-1:0] m9_p;

  // Sum and drop 32 fraction bits
  always_ff @(posedge clk) begin
    if (adv) begin
      m9_side <= m8_side;
      m9_sat  <= m8_sat;
      m9_neg  <= m8_neg;
      m9_p    <= BIG_W'(m8_pl >> 32) + m8_ph;
    end
  end

  // ---------------------------------------------------------------- divider seed
  div2_t            d2 [Q2_W+1];
  logic             m10_ovf;
  logic [BIG_W-1:0] m10_pshl;

  assign m10_ovf  = {8'd0, m9_p} >= (72'(m9_side.m) << SH_OV2);
  assign m10_pshl = m9_p << FRAC_BITS;

  // Check for a 48-bit overflow and seed the magnitude divider
  always_ff @(posedge clk) begin
    if (adv) begin
      d2[0].side <= m9_side;
      d2[0].neg  <= m9_neg;
      d2[0].sat  <= m9_sat | m10_ovf;
      d2[0].rem  <= M_W'(m9_p >> SH_OV2);
      d2[0].low  <= m10_pshl[Q2_W-1:0];
      d2[0].q    <= '0;
    end
  end

  // ---------------------------------------------------------------- magnitude divider
  for (genvar j = 0; j < Q2_W; j++) begin : g_div2
    logic [M_W:0]   nr;
    logic           ge;
    logic [M_W-1:0] rem_next;

    assign nr       = {d2[j].rem, d2[j].low[Q2_W-1]};
    assign ge       = nr >= {1'b0, d2[j].side.m};
    assign rem_next = ge ? M_W'(nr - {1'b0, d2[j].side.m}) : nr[M_W-1:0];

    // Resolve one quotient bit
    always_ff @(posedge clk) begin
      if (adv) begin
        d2[j+1].side <= d2[j].side;
        d2[j+1].neg  <= d2[j].neg;
        d2[j+1].sat  <= d2[j].sat;
        d2[j+1].rem  <= rem_next;
        d2[j+1].low  <= {d2[j].low[Q2_W-2:0], 1'b0};
        d2[j+1].q    <= {d2[j].q[Q2_W-2:0], ge};
      end
    end
  end

  // ---------------------------------------------------------------- result
  div2_t              fin;
  logic               fin_big, fin_sat;
  logic [FORCE_W-1:0] fin_force;
  logic               fin_flag;

  assign fin     = d2[Q2_W];
  assign fin_big = fin.neg ? (fin.q > FORCE_NEG) : fin.q[Q2_W-1];
  assign fin_sat = fin.sat | fin_big;

  // Pick the force for out-of-range, zero distance, zero epsilon and clamped items, else the signed quotient
  always_comb begin
    fin_force = '0;
    fin_flag  = 1'b0;
    if (!fin.side.applied) begin
      fin_force = '0;
    end else if (fin.side.zero) begin
      fin_force = FORCE_POS;
      fin_flag  = 1'b1;
    end else if (fin.side.eps0) begin
      fin_force = '0;
    end else if (fin_sat) begin
      fin_force = fin.neg ? FORCE_NEG : FORCE_POS;
      fin_flag  = 1'b1;
    end else begin
      fin_force = fin.neg ? FORCE_W'(-fin.q) : fin.q;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.force_res <= fin_force;
      out_ch.applied   <= fin.side.applied;
      out_ch.saturated <= fin_flag;
    end
  end

endmodule

`default_nettype wire
